/* design/sfd_pkg.sv */
// Package for the serial frame deframer: constants, phase and role codes, result type.
package sfd_pkg;

  // Frame layout
  localparam int unsigned ADDRESS_BYTES   = 5;
  localparam logic [7:0]  SYNC_FIRST      = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND     = 8'h55;
  localparam logic [15:0] LENGTH_OVERHEAD = 16'd4;
  localparam logic [15:0] LENGTH_RESET    = 16'd256;

  // Parse phases
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_SRC   = 4'd2,
    PH_DEST  = 4'd3,
    PH_LEN   = 4'd4,
    PH_VER   = 4'd5,
    PH_SER   = 4'd6,
    PH_CMD   = 4'd7,
    PH_DATA  = 4'd8,
    PH_CHK   = 4'd9
  } phase_t;

  // Byte role codes
  localparam logic [3:0] ROLE_DISCARD  = 4'd0;
  localparam logic [3:0] ROLE_SYNC     = 4'd1;
  localparam logic [3:0] ROLE_SOURCE   = 4'd2;
  localparam logic [3:0] ROLE_DEST     = 4'd3;
  localparam logic [3:0] ROLE_LENGTH   = 4'd4;
  localparam logic [3:0] ROLE_VERSION  = 4'd5;
  localparam logic [3:0] ROLE_SERIAL   = 4'd6;
  localparam logic [3:0] ROLE_COMMAND  = 4'd7;
  localparam logic [3:0] ROLE_PAYLOAD  = 4'd8;
  localparam logic [3:0] ROLE_CHECKSUM = 4'd9;

  // One tagged byte
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_role;
    logic [15:0] field_offset;
    logic        frame_done;
    logic        checksum_ok;
    logic        length_error;
  } result_t;

endpackage

/* design/sfd_parser.sv */
// Frame parser: parse state, length limit register and per-byte tagging logic.
module sfd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_data,
  output sfd_pkg::result_t result
);
  import sfd_pkg::*;

  localparam logic [15:0] ADDR_LAST = 16'(ADDRESS_BYTES);

  phase_t      parse_phase, parse_phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] payload_pos, payload_pos_next;
  logic [15:0] length_limit;

  logic [15:0] len_word;
  logic [15:0] counter_inc;
  logic [15:0] counter_dec;
  logic [15:0] counter_net;
  logic [7:0]  sum_add;

  assign len_word    = {rx_byte, length_low_byte};
  assign counter_inc = byte_counter + 16'd1;
  assign counter_dec = byte_counter - 16'd1;
  assign counter_net = (byte_counter >= LENGTH_OVERHEAD) ?
                       (byte_counter - LENGTH_OVERHEAD) : 16'd0;
  assign sum_add     = running_sum + rx_byte;

  // Next state and tag for the incoming byte
  always_comb begin
    parse_phase_next     = parse_phase;
    byte_counter_next    = byte_counter;
    length_low_byte_next = length_low_byte;
    running_sum_next     = running_sum;
    payload_pos_next     = payload_pos;

    result.byte_out     = rx_byte;
    result.byte_role    = ROLE_DISCARD;
    result.field_offset = 16'd0;
    result.frame_done   = 1'b0;
    result.checksum_ok  = 1'b0;
    result.length_error = 1'b0;

    case (parse_phase)
      PH_SYNC2: begin
        // anything other than the second sync byte is dropped, keep waiting
        if (rx_byte == SYNC_SECOND) begin
          result.byte_role    = ROLE_SYNC;
          result.field_offset = 16'd1;
          byte_counter_next   = 16'd0;
          parse_phase_next    = PH_SRC;
        end
      end
      PH_SRC, PH_DEST: begin
        result.byte_role    = (parse_phase == PH_SRC) ? ROLE_SOURCE : ROLE_DEST;
        result.field_offset = byte_counter;
        byte_counter_next   = counter_inc;
        if (counter_inc >= ADDR_LAST) begin
          byte_counter_next = 16'd0;
          parse_phase_next  = (parse_phase == PH_SRC) ? PH_DEST : PH_LEN;
        end
      end
      PH_LEN: begin
        result.byte_role    = ROLE_LENGTH;
        result.field_offset = byte_counter;
        if (byte_counter == 16'd0) begin
          length_low_byte_next = rx_byte;
          byte_counter_next    = 16'd1;
        end else if (len_word >= length_limit) begin
          // oversize frame: flag and resume hunting
          result.length_error = 1'b1;
          byte_counter_next   = 16'd0;
          parse_phase_next    = PH_HUNT;
        end else begin
          byte_counter_next = len_word;
          running_sum_next  = 8'd0;
          parse_phase_next  = PH_VER;
        end
      end
      PH_VER: begin
        result.byte_role = ROLE_VERSION;
        running_sum_next = sum_add;
        parse_phase_next = PH_SER;
      end
      PH_SER: begin
        result.byte_role = ROLE_SERIAL;
        running_sum_next = sum_add;
        parse_phase_next = PH_CMD;
      end
      PH_CMD: begin
        // payload count is length minus header overhead, floored at zero
        result.byte_role  = ROLE_COMMAND;
        running_sum_next  = sum_add;
        byte_counter_next = counter_net;
        payload_pos_next  = 16'd0;
        parse_phase_next  = (counter_net != 16'd0) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        result.byte_role    = ROLE_PAYLOAD;
        result.field_offset = payload_pos;
        payload_pos_next    = payload_pos + 16'd1;
        running_sum_next    = sum_add;
        byte_counter_next   = counter_dec;
        if (counter_dec == 16'd0) begin
          parse_phase_next = PH_CHK;
        end
      end
      PH_CHK: begin
        result.byte_role   = ROLE_CHECKSUM;
        result.frame_done  = 1'b1;
        result.checksum_ok = (running_sum == rx_byte);
        parse_phase_next   = PH_HUNT;
      end
      default: begin
        // hunting for the first sync byte
        if (rx_byte == SYNC_FIRST) begin
          result.byte_role = ROLE_SYNC;
          parse_phase_next = PH_SYNC2;
        end else begin
          parse_phase_next = PH_HUNT;
        end
      end
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HUNT;
      byte_counter    <= 16'd0;
      length_low_byte <= 8'd0;
      running_sum     <= 8'd0;
      payload_pos     <= 16'd0;
    end else if (take) begin
      parse_phase     <= parse_phase_next;
      byte_counter    <= byte_counter_next;
      length_low_byte <= length_low_byte_next;
      running_sum     <= running_sum_next;
      payload_pos     <= payload_pos_next;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LENGTH_RESET;
    end else if (cfg_write) begin
      length_limit <= cfg_data;
    end
  end

endmodule

/* design/serial_frame_deframer.sv */
// Serial frame deframer top level: input handshake, parser and two-entry result buffer.
// A byte's tagged result is registered into the result buffer when the byte is accepted, and is offered from its head.
// Throughput: one byte per cycle while the buffer has room; the parser updates its
// state on each accepted byte, and a two-entry result buffer lets input continue
// while one result waits. Input stalls only when both result entries are held.
// Reset (rst, synchronous): parser hunts for the first sync byte, counters and sum
// clear, length_limit returns to 256, result buffer empties.
module serial_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] length_limit,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  byte_out,
  output logic [3:0]  byte_role,
  output logic [15:0] field_offset,
  output logic        frame_done,
  output logic        checksum_ok,
  output logic        length_error
);
  import sfd_pkg::*;

  logic    push, pop;
  result_t parsed;
  result_t buf_q [2];
  logic    wr_ptr, rd_ptr;
  logic [1:0] count;
  result_t head;

  assign cfg_ready  = 1'b1;
  assign byte_stall = (count == 2'd2);
  assign push       = byte_valid && !byte_stall;
  assign pop        = result_valid && !result_stall;

  sfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (push),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (length_limit),
    .result    (parsed)
  );

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= parsed;
  end

  // Head of buffer drives the result ports
  assign head         = buf_q[rd_ptr];
  assign result_valid = (count != 2'd0);
  assign byte_out     = head.byte_out;
  assign byte_role    = head.byte_role;
  assign field_offset = head.field_offset;
  assign frame_done   = head.frame_done;
  assign checksum_ok  = head.checksum_ok;
  assign length_error = head.length_error;

endmodule
